>>> src/slt_pkg.sv
// Shared constants and types for the sorted list table.
`timescale 1ns / 1ps
`default_nettype none
package slt_pkg;
   localparam int CAPACITY = 64;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 32;
   localparam int INDEX_W  = 6;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int ECOUNT_W = 7;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_READ   = 2'd1;
   localparam logic [OP_W-1:0] OP_FIND   = 2'd2;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic                      wr_insert;
      logic                      wr_remove;
      logic signed [KEY_W-1:0]   key;
      logic [INDEX_W-1:0]        index;
      logic [COUNT_W-1:0]        count;
   } cmd_type;

   // What a cell shows to its neighbors.
   typedef struct packed {
      logic signed [KEY_W-1:0] entry;
      logic                    ge;
      logic                    valid;
   } link_type;
endpackage
`default_nettype wire

>>> src/slt_if.sv
// Request and response channel interfaces of the sorted list table.
`timescale 1ns / 1ps
`default_nettype none
interface slt_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [slt_pkg::OP_W-1:0]               opcode;
   logic signed [slt_pkg::KEY_W-1:0]       key_value;
   logic [slt_pkg::INDEX_W-1:0]            index;
   modport source (output valid, output opcode, output key_value, output index,
                   input ready);
   modport sink   (input valid, input opcode, input key_value, input index,
                   output ready);
endinterface

interface slt_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [slt_pkg::STATUS_W-1:0]           status;
   logic signed [slt_pkg::KEY_W-1:0]       read_value;
   logic [slt_pkg::ECOUNT_W-1:0]           entry_count;
   modport source (output valid, output status, output read_value,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input read_value,
                   input entry_count, output ready);
endinterface
`default_nettype wire

>>> src/sorted_list_table.sv
// Top level of the sorted list table: cell row, count and response register.
// Keeps up to CAPACITY signed 32-bit values in ascending order in a row of
// cells, one entry per cell. For every command (insert, read at index, find,
// remove) all cells compare the key at once; insert and remove shift cells
// by one place toward or away from their neighbor, and the response is
// registered, so a new command is taken every cycle while the response side
// keeps up. The path that sets the clock is the key compare in every cell,
// the OR over the row that finds a match, and the shift select. No clearing
// pass is needed after reset; only the count and response valid are cleared.
`timescale 1ns / 1ps
`default_nettype none
module sorted_list_table (
   input  wire        clock,
   input  wire        reset,
   slt_req_if.sink    req_bus,
   slt_rsp_if.source  rsp_bus
);
   localparam int N = slt_pkg::CAPACITY;

   logic                               accept;
   logic [slt_pkg::COUNT_W-1:0]        count_ff;
   logic [slt_pkg::COUNT_W-1:0]        count_in;
   logic                               rsp_valid_ff;
   logic [slt_pkg::STATUS_W-1:0]       status_ff;
   logic [slt_pkg::STATUS_W-1:0]       status_in;
   logic signed [slt_pkg::KEY_W-1:0]   read_ff;
   logic signed [slt_pkg::KEY_W-1:0]   read_in;
   logic                               full;
   logic                               present;
   logic signed [slt_pkg::KEY_W-1:0]   read_any;
   logic                               in_range;
   slt_pkg::cmd_type                   cmd;
   slt_pkg::link_type                  links [N+1];
   logic signed [slt_pkg::KEY_W-1:0]   read_parts [N];
   logic [N-1:0]                       found_bits;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   assign full     = count_ff >= slt_pkg::COUNT_W'(N);
   assign in_range = 32'(req_bus.index) < 32'(count_ff);
   assign present  = |found_bits;

   assign cmd.key       = req_bus.key_value;
   assign cmd.index     = req_bus.index;
   assign cmd.count     = count_ff;
   assign cmd.wr_insert = (req_bus.opcode == slt_pkg::OP_INSERT) && !full;
   assign cmd.wr_remove = (req_bus.opcode == slt_pkg::OP_REMOVE) && present;

   assign links[0].entry = '0;
   assign links[0].ge    = 1'b0;
   assign links[0].valid = 1'b1;

   for (genvar i = 0; i < N; i++) begin : g_cell
      slt_pkg::link_type nxt;
      slt_pkg::link_type out_l;
      if (i == N - 1) begin : g_last
         assign nxt.entry = '0;
         assign nxt.ge    = 1'b0;
         assign nxt.valid = 1'b0;
      end else begin : g_mid
         assign nxt = links[i+2];
      end
      slt_cell u_cell (
         .clock     (clock),
         .write_en  (accept),
         .cell_idx  (slt_pkg::COUNT_W'(i)),
         .cmd       (cmd),
         .prev_link (links[i]),
         .next_link (nxt),
         .out_link  (out_l),
         .read_part (read_parts[i]),
         .found     (found_bits[i])
      );
      assign links[i+1] = out_l;
   end

   always_comb begin
      read_any = '0;
      for (int i = 0; i < N; i++) begin
         read_any = read_any | read_parts[i];
      end
   end

   always_comb begin
      status_in = slt_pkg::ST_OK;
      read_in   = '0;
      count_in  = count_ff;
      case (req_bus.opcode)
         slt_pkg::OP_INSERT: begin
            if (full) begin
               status_in = slt_pkg::ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         slt_pkg::OP_READ: begin
            if (in_range) begin
               read_in = read_any;
            end else begin
               status_in = slt_pkg::ST_RANGE;
            end
         end
         slt_pkg::OP_FIND: begin
            if (!present) begin
               status_in = slt_pkg::ST_ABSENT;
            end
         end
         slt_pkg::OP_REMOVE: begin
            if (present) begin
               count_in = count_ff - 1'b1;
            end else begin
               status_in = slt_pkg::ST_ABSENT;
            end
         end
         default: begin
            status_in = slt_pkg::ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         read_ff   <= read_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.read_value  = read_ff;
   assign rsp_bus.entry_count = slt_pkg::ECOUNT_W'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= slt_pkg::COUNT_W'(N))
      else $error("entry count past capacity");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_bus.entry_count == slt_pkg::ECOUNT_W'(count_ff)))
      else $error("response count differs from table count");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_bus.opcode == slt_pkg::OP_INSERT) && full)
      |=> (status_ff == slt_pkg::ST_FULL) && (count_ff == $past(count_ff)))
      else $error("insert into full table not flagged");

   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff != slt_pkg::ST_OK)) |-> (read_ff == '0))
      else $error("read value nonzero on failed command");
endmodule
`default_nettype wire

>>> src/slt_cell.sv
// One table cell: holds one entry, compares it and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module slt_cell (
   input  wire                                 clock,
   input  wire                                 write_en,
   input  wire [slt_pkg::COUNT_W-1:0]          cell_idx,
   input  wire slt_pkg::cmd_type               cmd,
   input  wire slt_pkg::link_type              prev_link,
   input  wire slt_pkg::link_type              next_link,
   output slt_pkg::link_type                   out_link,
   output logic signed [slt_pkg::KEY_W-1:0]    read_part,
   output logic                                found
);
   logic signed [slt_pkg::KEY_W-1:0] entry_ff;
   logic signed [slt_pkg::KEY_W-1:0] entry_in;
   logic                             valid;
   logic                             ge;

   assign valid = cell_idx < cmd.count;
   assign ge    = valid && (entry_ff >= cmd.key);
   assign found = ge && !prev_link.ge && (entry_ff == cmd.key);
   assign read_part = (valid && (32'(cell_idx) == 32'(cmd.index))) ? entry_ff : '0;

   assign out_link.entry = entry_ff;
   assign out_link.ge    = ge;
   assign out_link.valid = valid;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.wr_insert) begin
         if (prev_link.ge) begin
            entry_in = prev_link.entry;
         end else if (ge || (!valid && prev_link.valid)) begin
            entry_in = cmd.key;
         end
      end else if (cmd.wr_remove && ge) begin
         entry_in = next_link.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         entry_ff <= entry_in;
      end
   end
endmodule
`default_nettype wire
